// File: rtl/ure_pkg.sv
// Package for the understeer ratio estimator: types, constants, CORDIC angle table.
package ure_pkg;

  localparam int TAN_STEPS_DEF = 16;

  // configuration register indexes
  localparam logic [2:0] REG_DECAY  = 3'd0;
  localparam logic [2:0] REG_FLOOR  = 3'd1;
  localparam logic [2:0] REG_SPEED  = 3'd2;
  localparam logic [2:0] REG_STEER  = 3'd3;
  localparam logic [2:0] REG_YAW    = 3'd4;
  localparam logic [2:0] REG_RATIO  = 3'd5;
  localparam logic [2:0] REG_WBASE  = 3'd6;

  // gate status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_SLOW    = 2'd1;
  localparam logic [1:0] ST_SMALLR  = 2'd2;
  localparam logic [1:0] ST_SMALLC  = 2'd3;

  localparam logic [23:0] DEG180_Q16   = 24'd11796480;
  localparam logic [23:0] DEG90_Q16    = 24'd5898240;
  localparam logic [21:0] YAW_SCALE_Q8 = 22'd3666930;
  localparam logic [40:0] REF_CAP      = 41'h100_0000_0000;
  localparam logic [23:0] RATIO_MAX    = 24'h7FFFFF;
  localparam logic [23:0] RATIO_MIN    = 24'h800000;
  localparam logic [23:0] RATIO_ONE    = 24'd4096;

  // 180 degrees in Q16 is 45 * 2^18; reduce the upper part modulo 45 by
  // multiplying with ceil(2^23 / 45), exact for values below 2^18
  localparam logic [21:0] DEG180_HI    = 22'd45;
  localparam logic [21:0] DEG180_RECIP = 22'd186414;

  typedef enum logic [4:0] {
    S_IDLE, S_FRIC, S_PEAK, S_DIV, S_MOD, S_MQ, S_ZSET, S_CORD, S_NY, S_NC, S_D,
    S_DST, S_RMAG, S_G2, S_GRIP, S_SQ, S_SAT, S_C, S_G3, S_Q, S_DONE
  } state_t;

  // arctangent of 2^-i in degrees, Q16
  function automatic logic [21:0] atan_deg(input logic [4:0] i);
    logic [21:0] v;
    case (i)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740968;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

  // magnitude of a 16-bit signed value
  function automatic logic [15:0] mag16(input logic signed [15:0] v);
    return v[15] ? 16'(-v) : 16'(v);
  endfunction

endpackage

// File: rtl/understeer_ratio_estimator.sv
// Understeer ratio estimator: sequencer over a shared multiplier, divider and CORDIC stage.
//
// Input channel (in_valid / in_stall): one vehicle sample per transaction.
// in_stall is high from the cycle after a transaction until the sample's result
// has been moved to the output register; one sample is worked on at a time.
// Output channel (out_valid / out_stall): yaw_ratio, gate_status and
// friction_estimate. The output register holds a result while out_stall is
// high, and a new sample may be taken meanwhile; the block waits at the end of
// the next sample until the register is free.
// A sample gated on speed or steering goes from S_PEAK straight to S_DONE; the
// time of a full sample is set by the one-bit-per-cycle restoring
// divider (36 + 62 + 31 + 36 steps for the four divisions) and one CORDIC
// rotation per cycle. The next transaction can be taken in the cycle after
// the result is loaded.
// Reset (rst, synchronous) loads the default configuration and clears the
// friction peak, so the first sample yields the larger of the floor and its lateral accel.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once; the user
// must make them only while no sample is in flight; the block does not enforce it.
module understeer_ratio_estimator
  import ure_pkg::*;
#(
  parameter int TAN_STEPS = TAN_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] speed,
  input  logic signed [15:0] wheel_angle,
  input  logic signed [15:0] yaw_rate,
  input  logic signed [15:0] lateral_accel,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [23:0] yaw_ratio,
  output logic [1:0]         gate_status,
  output logic [14:0]        friction_estimate
);

  // configuration
  logic [15:0] decay_factor;
  logic [14:0] friction_floor, speed_gate, steer_gate, yaw_gate;
  logic [15:0] steering_ratio;
  logic [12:0] wheelbase_mm;

  always_ff @(posedge clk) begin
    if (rst) begin
      decay_factor   <= 16'd65405;
      friction_floor <= 15'd1229;
      speed_gate     <= 15'd768;
      steer_gate     <= 15'd80;
      yaw_gate       <= 15'd32;
      steering_ratio <= 16'd3840;
      wheelbase_mm   <= 13'd2575;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DECAY: decay_factor   <= cfg_data;
        REG_FLOOR: friction_floor <= cfg_data[14:0];
        REG_SPEED: speed_gate     <= cfg_data[14:0];
        REG_STEER: steer_gate     <= cfg_data[14:0];
        REG_YAW:   yaw_gate       <= cfg_data[14:0];
        REG_RATIO: steering_ratio <= cfg_data;
        REG_WBASE: wheelbase_mm   <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  state_t state, state_next, div_ret;

  // captured sample
  logic [15:0] mspeed, mwheel, myaw;
  logic        sspeed, swheel, syaw;
  logic [14:0] lat;
  logic [14:0] friction_peak;

  // shared multiplier
  logic [40:0] mul_a;
  logic [21:0] mul_b;
  logic [62:0] prod;

  // shared divider
  logic [63:0] dnum, quo;
  logic [40:0] rem, dv;
  logic [5:0]  dcnt;
  logic [41:0] rs;
  logic        dfit;

  // CORDIC
  logic signed [26:0] cx, cy;
  logic signed [25:0] cz;
  logic [4:0]         ci;
  logic signed [26:0] cx_sh, cy_sh;
  logic [26:0]        ax, ay;

  logic [40:0] rmag;
  logic [16:0] grip, sat;
  logic        neg;
  logic [23:0] res;
  logic [1:0]  status;

  logic        in_acc, out_free;
  logic [14:0] decayed, peak_new;
  logic [22:0] gate8;
  logic [23:0] mres;
  logic [17:0] hrem;
  logic [15:0] lat_in;
  logic signed [25:0] zred;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign rs       = {rem, dnum[63]};
  assign dfit     = rs >= {1'b0, dv};
  assign cx_sh    = cx >>> ci;
  assign cy_sh    = cy >>> ci;
  assign ax       = cx[26] ? 27'(-cx) : 27'(cx);
  assign ay       = cy[26] ? 27'(-cy) : 27'(cy);
  assign gate8    = {yaw_gate, 8'd0};
  assign lat_in   = mag16(lateral_accel);

  // angle modulo 180 degrees: upper bits modulo 45, low 18 bits pass through
  assign hrem     = quo[35:18] - prod[17:0];
  assign mres     = {hrem[5:0], quo[17:0]};

  // friction update from the decayed peak
  always_comb begin
    decayed  = prod[30:16];
    if (decayed < friction_floor) decayed = friction_floor;
    peak_new = (lat > decayed) ? lat : decayed;
  end

  // road angle reduced into [-90, 90) degrees, then negated for a negative wheel angle
  always_comb begin
    zred = (mres >= DEG90_Q16) ? 26'($signed({2'b0, mres}) - $signed({2'b0, DEG180_Q16}))
                               : $signed({2'b0, mres});
    if (swheel) zred = -zred;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_acc) state_next = S_FRIC;
      S_FRIC: state_next = S_PEAK;
      S_PEAK: begin
        if (mspeed < {1'b0, speed_gate} || mwheel < {1'b0, steer_gate}) state_next = S_DONE;
        else state_next = S_DIV;
      end
      S_DIV:  if (dcnt == 6'd1) state_next = div_ret;
      S_MOD:  state_next = S_MQ;
      S_MQ:   state_next = S_ZSET;
      S_ZSET: state_next = S_CORD;
      S_CORD: if (ci == 5'(TAN_STEPS - 1)) state_next = S_NY;
      S_NY:   state_next = S_NC;
      S_NC:   state_next = S_D;
      S_D:    state_next = S_DST;
      S_DST:  state_next = (prod == 63'd0) ? S_G2 : S_DIV;
      S_RMAG: state_next = S_G2;
      S_G2: begin
        if (rmag < {18'd0, gate8}) state_next = S_DONE;
        else if (lat == 15'd0 || lat >= friction_peak) state_next = S_SQ;
        else state_next = S_DIV;
      end
      S_GRIP: state_next = S_SQ;
      S_SQ:   state_next = S_SAT;
      S_SAT:  state_next = S_C;
      S_C:    state_next = S_G3;
      S_G3: begin
        if (prod[56:16] < {18'd0, gate8} || myaw == 16'd0 || prod[56:16] == 41'd0)
          state_next = S_DONE;
        else state_next = S_DIV;
      end
      S_Q:    state_next = S_DONE;
      S_DONE: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer: handshake and multiplier operands
  always_comb begin
    in_stall = (state != S_IDLE);
    mul_a = 41'd0;
    mul_b = 22'd0;
    unique case (state)
      S_FRIC: begin mul_a = {26'd0, friction_peak}; mul_b = {6'd0, decay_factor}; end
      S_MOD:  begin mul_a = {23'd0, quo[35:18]};   mul_b = DEG180_RECIP; end
      S_MQ:   begin mul_a = {23'd0, prod[40:23]};  mul_b = DEG180_HI; end
      S_NY:   begin mul_a = {14'd0, ay};  mul_b = {6'd0, mspeed}; end
      S_NC:   begin mul_a = prod[40:0];   mul_b = YAW_SCALE_Q8; end
      S_D:    begin mul_a = {14'd0, ax};  mul_b = {9'd0, wheelbase_mm}; end
      S_SQ:   begin mul_a = {24'd0, grip}; mul_b = {5'd0, grip}; end
      S_C:    begin mul_a = rmag;          mul_b = {5'd0, sat}; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= 63'(mul_a * mul_b);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      friction_peak <= 15'd0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_PEAK) friction_peak <= peak_new;
      if (state == S_DONE && out_free) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: if (in_acc) begin
        mspeed <= mag16(speed);       sspeed <= speed[15];
        mwheel <= mag16(wheel_angle); swheel <= wheel_angle[15];
        myaw   <= mag16(yaw_rate);    syaw   <= yaw_rate[15];
        lat    <= (lat_in > 16'd32767) ? 15'd32767 : lat_in[14:0];
        res    <= RATIO_ONE;
        status <= ST_OK;
      end
      S_PEAK: begin
        if (mspeed < {1'b0, speed_gate} || mwheel < {1'b0, steer_gate}) status <= ST_SLOW;
        dnum    <= {mwheel, 48'd0};
        dv      <= {25'd0, (steering_ratio == 16'd0) ? 16'd1 : steering_ratio};
        rem     <= 41'd0; quo <= 64'd0; dcnt <= 6'd36;
        div_ret <= S_MOD;
      end
      S_DIV: begin
        dnum <= {dnum[62:0], 1'b0};
        dcnt <= dcnt - 6'd1;
        if (dfit) begin
          rem <= 41'(rs - {1'b0, dv});
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= rs[40:0];
          quo <= {quo[62:0], 1'b0};
        end
      end
      S_ZSET: begin
        cx <= 27'sd16777216; cy <= 27'sd0; cz <= zred; ci <= 5'd0;
      end
      S_CORD: begin
        if (!cz[25]) begin
          cx <= cx - cy_sh; cy <= cy + cx_sh; cz <= cz - $signed({4'd0, atan_deg(ci)});
        end else begin
          cx <= cx + cy_sh; cy <= cy - cx_sh; cz <= cz + $signed({4'd0, atan_deg(ci)});
        end
        ci <= ci + 5'd1;
      end
      S_NY: neg <= sspeed ^ cy[26] ^ cx[26];
      S_D:  dnum <= {prod[61:0], 2'b0};
      S_DST: begin
        if (prod == 63'd0) rmag <= REF_CAP;
        dv      <= prod[40:0];
        rem     <= 41'd0; quo <= 64'd0; dcnt <= 6'd62;
        div_ret <= S_RMAG;
      end
      S_RMAG: rmag <= (quo > {23'd0, REF_CAP}) ? REF_CAP : quo[40:0];
      S_G2: begin
        if (rmag < {18'd0, gate8}) status <= ST_SMALLR;
        if (lat == 15'd0) grip <= 17'd0;
        else if (lat >= friction_peak) grip <= 17'd65536;
        dnum    <= {lat, 49'd0};
        dv      <= {26'd0, friction_peak};
        rem     <= 41'd0; quo <= 64'd0; dcnt <= 6'd31;
        div_ret <= S_GRIP;
      end
      S_GRIP: grip <= quo[16:0];
      S_SAT:  sat  <= 17'(18'd65536 - {1'b0, prod[32:16]});
      S_G3: begin
        if (prod[56:16] < {18'd0, gate8}) status <= ST_SMALLC;
        else if (myaw == 16'd0) res <= 24'd0;
        else if (prod[56:16] == 41'd0) res <= (neg ^ syaw) ? RATIO_MIN : RATIO_MAX;
        neg     <= neg ^ syaw;
        dnum    <= {myaw, 48'd0};
        dv      <= prod[56:16];
        rem     <= 41'd0; quo <= 64'd0; dcnt <= 6'd36;
        div_ret <= S_Q;
      end
      S_Q: begin
        if (neg) res <= (quo > 64'd8388608) ? RATIO_MIN : 24'(-quo);
        else     res <= (quo > 64'd8388607) ? RATIO_MAX : quo[23:0];
      end
      S_DONE: if (out_free) begin
        yaw_ratio         <= res;
        gate_status       <= status;
        friction_estimate <= friction_peak;
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/ure_checker.sv
// Port-level checker for the understeer ratio estimator, bound to the top level.
module ure_checker
  import ure_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [23:0] yaw_ratio,
  input logic [1:0]         gate_status
);

  // the block is busy after a transaction while it works on the sample
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again right after a transaction");

  // gated results read as one
  a_gated: assert property (@(posedge clk) disable iff (rst)
    (out_valid && gate_status != ST_OK) |-> yaw_ratio == RATIO_ONE)
    else $error("gated result is not 1.0");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(yaw_ratio) && $stable(gate_status)))
    else $error("stalled result changed");

endmodule

bind understeer_ratio_estimator ure_checker u_ure_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall),
  .yaw_ratio(yaw_ratio), .gate_status(gate_status)
);

// File: verif/tb_understeer_ratio_estimator.sv
// Testbench for the understeer ratio estimator: directed table, random samples, predictor check.
`timescale 1ns / 1ps

module tb_understeer_ratio_estimator;
  import ure_pkg::*;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [15:0]        cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic signed [15:0] speed;
  logic signed [15:0] wheel_angle;
  logic signed [15:0] yaw_rate;
  logic signed [15:0] lateral_accel;
  logic               out_valid;
  logic               out_stall;
  logic signed [23:0] yaw_ratio;
  logic [1:0]         gate_status;
  logic [14:0]        friction_estimate;

  understeer_ratio_estimator dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .speed(speed), .wheel_angle(wheel_angle), .yaw_rate(yaw_rate),
    .lateral_accel(lateral_accel),
    .out_valid(out_valid), .out_stall(out_stall),
    .yaw_ratio(yaw_ratio), .gate_status(gate_status),
    .friction_estimate(friction_estimate)
  );

  typedef struct packed {
    logic [23:0] ratio;
    logic [1:0]  status;
    logic [14:0] friction;
  } ratio_result_t;

  typedef struct {
    logic [15:0]   sp, wh, yw, la;
    bit            typed;
    ratio_result_t res;
  } sample_row_t;

  // CORDIC angle steps, arctan(2^-i) in degrees Q16
  localparam longint ATAN_STEP [16] = '{
    2949120, 1740968, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115
  };
  localparam longint HALF_TURN = 11796480;
  localparam longint QUARTER_TURN = 5898240;
  localparam longint YAW_SCALE = 3666930;
  localparam longint unsigned CAP40 = 64'd1 << 40;
  localparam int WATCHDOG_LIMIT = 5000;

  // predictor state and configuration copy
  longint unsigned m_decay, m_floor, m_speed_gate, m_steer_gate, m_yaw_gate;
  longint unsigned m_ratio, m_wbase, m_peak;

  ratio_result_t expected_ratios[$];
  int errors;
  bit quiet;
  int stalled_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned abs16(logic signed [15:0] v);
    longint t;
    t = v;
    return (t < 0) ? longint'(-t) : t;
  endfunction

  // bit-true model of one sample; updates the friction peak
  function automatic ratio_result_t predict_sample(logic signed [15:0] sp, wh, yw, la);
    ratio_result_t r;
    longint unsigned lat_abs, decayed, pk, div, a, m, n, d, rmag, grip, sat, c, q;
    longint z, x, y, nx, result;
    bit neg;
    logic [1:0] st;
    lat_abs = abs16(la);
    decayed = (m_peak * m_decay) >> 16;
    if (decayed < m_floor) decayed = m_floor;
    if (lat_abs > 32767) lat_abs = 32767;
    pk = (lat_abs > decayed) ? lat_abs : decayed;
    m_peak = pk & 64'h7FFF;
    pk = m_peak;
    result = 4096;
    st = ST_OK;
    if (abs16(sp) < m_speed_gate || abs16(wh) < m_steer_gate) begin
      st = ST_SLOW;
    end else begin
      div = (m_ratio != 0) ? m_ratio : 1;
      a = (abs16(wh) << 20) / div;
      m = a % HALF_TURN;
      z = (m >= QUARTER_TURN) ? longint'(m) - HALF_TURN : longint'(m);
      if (wh < 0) z = -z;
      x = 64'sd1 << 24;
      y = 0;
      for (int i = 0; i < 16; i++) begin
        if (z >= 0) begin
          nx = x - (y >>> i);
          y = y + (x >>> i);
          z -= ATAN_STEP[i];
        end else begin
          nx = x + (y >>> i);
          y = y - (x >>> i);
          z += ATAN_STEP[i];
        end
        x = nx;
      end
      n = abs16(sp) * ((y < 0) ? longint'(-y) : y) * YAW_SCALE;
      d = m_wbase * ((x < 0) ? longint'(-x) : x);
      if (d == 0) rmag = CAP40;
      else begin
        rmag = n / d;
        if (rmag > CAP40) rmag = CAP40;
      end
      neg = ((sp < 0) != (y < 0)) != (x < 0);
      if (rmag < (m_yaw_gate << 8)) begin
        st = ST_SMALLR;
      end else begin
        if (lat_abs == 0) grip = 0;
        else if (lat_abs >= pk) grip = 65536;
        else grip = (lat_abs << 16) / pk;
        sat = 65536 - ((grip * grip) >> 16);
        c = (rmag * sat) >> 16;
        if (c < (m_yaw_gate << 8)) begin
          st = ST_SMALLC;
        end else begin
          neg = neg != (yw < 0);
          if (yw == 0) result = 0;
          else if (c == 0) result = neg ? -8388608 : 8388607;
          else begin
            q = (abs16(yw) << 20) / c;
            if (neg) result = (q > 8388608) ? -8388608 : -longint'(q);
            else result = (q > 8388607) ? 8388607 : longint'(q);
          end
        end
      end
    end
    r.ratio = result[23:0];
    r.status = st;
    r.friction = m_peak[14:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint exp_v, longint got_v);
    $display("mismatch %s: expected %0d got %0d at %0t", what, exp_v, got_v, $realtime);
    errors++;
  endtask

  // write all seven registers, then drop the enable
  task automatic load_config(input longint unsigned v[7]);
    for (int i = 0; i < 7; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= v[i][15:0];
      @(posedge clk);
      case (3'(i))
        REG_DECAY: m_decay = v[i] & 64'hFFFF;
        REG_FLOOR: m_floor = v[i] & 64'h7FFF;
        REG_SPEED: m_speed_gate = v[i] & 64'h7FFF;
        REG_STEER: m_steer_gate = v[i] & 64'h7FFF;
        REG_YAW:   m_yaw_gate = v[i] & 64'h7FFF;
        REG_RATIO: m_ratio = v[i] & 64'hFFFF;
        REG_WBASE: m_wbase = v[i] & 64'h1FFF;
        default: ;
      endcase
    end
    cfg_we <= 1'b0;
  endtask

  // offer one sample, wait for the transaction, record its prediction (or the typed result)
  task automatic send_sample(logic [15:0] sp, wh, yw, la, bit typed, ratio_result_t tr);
    ratio_result_t r;
    while (!quiet && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    speed <= sp;
    wheel_angle <= wh;
    yaw_rate <= yw;
    lateral_accel <= la;
    do @(posedge clk); while (in_stall);
    r = predict_sample(sp, wh, yw, la);
    expected_ratios.push_back(typed ? tr : r);
  endtask

  // sender pauses until every result is back
  task automatic drain;
    in_valid <= 1'b0;
    while (expected_ratios.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic send_random;
    logic [15:0] sp, wh, yw, la;
    if ($urandom_range(99) < 70) begin
      sp = 16'($urandom_range(12000, 600));
      wh = 16'($urandom_range(8000, 40));
      yw = 16'($urandom_range(4000));
      la = 16'($urandom_range(6000));
      if ($urandom_range(1)) sp = -sp;
      if ($urandom_range(1)) wh = -wh;
      if ($urandom_range(1)) yw = -yw;
      if ($urandom_range(1)) la = -la;
    end else begin
      sp = 16'($urandom);
      wh = 16'($urandom);
      yw = 16'($urandom);
      la = 16'($urandom);
    end
    send_sample(sp, wh, yw, la, 1'b0, '0);
  endtask

  // receiver back-pressure
  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 36);
  end

  // result checker
  always @(posedge clk) begin
    ratio_result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_ratios.size() == 0) begin
        report_mismatch("unexpected result, ratio", 0, yaw_ratio);
      end else begin
        e = expected_ratios.pop_front();
        if (yaw_ratio !== e.ratio)
          report_mismatch("yaw_ratio", $signed(e.ratio), yaw_ratio);
        if (gate_status !== e.status)
          report_mismatch("gate_status", e.status, gate_status);
        if (friction_estimate !== e.friction)
          report_mismatch("friction_estimate", e.friction, friction_estimate);
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      stalled_cycles <= 0;
    else
      stalled_cycles <= stalled_cycles + 1;
    if (stalled_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    sample_row_t rows[$];
    sample_row_t row;
    longint unsigned cfg[7];
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    speed = '0;
    wheel_angle = '0;
    yaw_rate = '0;
    lateral_accel = '0;
    out_stall = 1'b0;
    errors = 0;
    quiet = 1'b0;
    stalled_cycles = 0;
    m_decay = 65405; m_floor = 1229; m_speed_gate = 768; m_steer_gate = 80;
    m_yaw_gate = 32; m_ratio = 3840; m_wbase = 2575; m_peak = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table; typed rows: first sample floors, saturated lateral accel
    rows.push_back('{16'd0, 16'd0, 16'd0, 16'd0, 1, '{24'd4096, ST_SLOW, 15'd1229}});
    rows.push_back('{16'd0, 16'd500, 16'd100, 16'h7FFF, 1,
                     '{24'd4096, ST_SLOW, 15'd32767}});
    rows.push_back('{16'd5000, 16'd10, 16'd100, 16'h8000, 1,
                     '{24'd4096, ST_SLOW, 15'd32767}});
    rows.push_back('{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'd0, 0, '0});
    rows.push_back('{16'h8000, 16'h8000, 16'h8000, 16'd0, 0, '0});
    rows.push_back('{16'h7FFF, 16'h8000, 16'h7FFF, 16'd100, 0, '0});
    rows.push_back('{16'd5000, 16'd1600, 16'd0, 16'd0, 0, '0});
    rows.push_back('{16'd5000, 16'd1600, 16'd2000, 16'd500, 0, '0});
    rows.push_back('{16'hEC78, 16'd1600, 16'd2000, 16'd500, 0, '0});
    rows.push_back('{16'd5000, 16'hF9C0, 16'hF830, 16'hFE0C, 0, '0});
    rows.push_back('{16'd5000, 16'd1600, 16'd2000, 16'h7FFF, 0, '0});
    rows.push_back('{16'd768, 16'd80, 16'd1, 16'd1, 0, '0});
    rows.push_back('{16'd767, 16'd80, 16'd1, 16'd1, 0, '0});
    rows.push_back('{16'd768, 16'd79, 16'd1, 16'd1, 0, '0});
    rows.push_back('{16'd800, 16'd81, 16'd3, 16'd0, 0, '0});
    rows.push_back('{16'd20000, 16'd24000, 16'd8000, 16'd2000, 0, '0});
    foreach (rows[i]) begin
      row = rows[i];
      send_sample(row.sp, row.wh, row.yw, row.la, row.typed, row.res);
    end
    drain();

    // corner configuration: zero ratio, zero wheelbase, zero yaw gate, zero decay and gates
    cfg = '{0, 1, 0, 0, 0, 0, 0};
    load_config(cfg);
    rows.delete();
    rows.push_back('{16'd5000, 16'd1600, 16'd2000, 16'd500, 0, '0});
    rows.push_back('{16'd5000, 16'd1600, 16'd2000, 16'h7FFF, 0, '0});
    rows.push_back('{16'd0, 16'd0, 16'd0, 16'd0, 0, '0});
    rows.push_back('{16'h8000, 16'd3, 16'h8000, 16'h7FFF, 0, '0});
    foreach (rows[i]) begin
      row = rows[i];
      send_sample(row.sp, row.wh, row.yw, row.la, 1'b0, '0);
    end
    for (int k = 0; k < 20; k++) send_random();
    drain();

    // maximum register values
    cfg = '{65535, 32767, 32767, 32767, 32767, 65535, 8191};
    load_config(cfg);
    for (int k = 0; k < 40; k++) send_random();
    send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, '0);
    drain();

    // random phases, the defaults among them, one run without idling
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 0) cfg = '{65405, 1229, 768, 80, 32, 3840, 2575};
      else cfg = '{$urandom_range(65535, 60000), $urandom_range(4000, 1),
                   $urandom_range(2000), $urandom_range(400), $urandom_range(200),
                   $urandom_range(8000, 256), $urandom_range(8000, 500)};
      load_config(cfg);
      quiet = (ph == 3);
      for (int k = 0; k < 310; k++) send_random();
      drain();
    end
    quiet = 1'b0;

    if (errors == 0 && expected_ratios.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/ure_pkg.sv
rtl/understeer_ratio_estimator.sv
rtl/ure_checker.sv
verif/tb_understeer_ratio_estimator.sv
